// ===== rtl/core/info_frame_byte_stuffer_assert.svh =====
// Assertion macros for the byte stuffer. Defining SYNTH turns them into nothing.
`ifndef INFO_FRAME_BYTE_STUFFER_ASSERT_SVH
`define INFO_FRAME_BYTE_STUFFER_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, disabled while in reset
`define IFBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error("ifbs: assertion failed");

// next-cycle implication, disabled while in reset
`define IFBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
	else $error("ifbs: assertion failed");

`else

`define IFBS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IFBS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/ifbs_pkg.sv =====
`default_nettype none

package ifbs_pkg;

	localparam int BYTE_W = 8;
	localparam int CNT_W  = 8;

	localparam int MAX_STUFFED_PAYLOAD_DEF = 250;
	localparam int QUEUE_DEPTH_DEF         = 2;

	localparam logic [BYTE_W-1:0] FLAG_BYTE   = 8'h7e;
	localparam logic [BYTE_W-1:0] ESC_BYTE    = 8'h7d;
	localparam logic [BYTE_W-1:0] ESC_OF_ESC  = 8'h5d;
	localparam logic [BYTE_W-1:0] ESC_OF_FLAG = 8'h5e;
	localparam logic [BYTE_W-1:0] CTRL_SEQ0   = 8'h00;
	localparam logic [BYTE_W-1:0] CTRL_SEQ1   = 8'h40;
	localparam logic [BYTE_W-1:0] ADDR_RESET  = 8'h03;

	// one classified payload byte, with everything the back end needs to emit it
	typedef struct packed {
		logic              hdr;    // open a frame first
		logic [BYTE_W-1:0] addr;
		logic              seq;
		logic              esc;    // escaped: 0x7d then data
		logic [BYTE_W-1:0] data;   // raw byte, or the escape code when esc
		logic              close;  // BCC2 and closing flag follow
		logic [BYTE_W-1:0] bcc2;
	} job_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_FLAG,
		PH_ADDR,
		PH_CTRL,
		PH_BCC1,
		PH_DATA0,
		PH_DATA1,
		PH_BCC2,
		PH_CLOSE
	} phase_t;

endpackage

`default_nettype wire

// ===== rtl/core/ifbs_front.sv =====
`default_nettype none

module ifbs_front #(
	parameter int MAX_STUFFED_PAYLOAD = ifbs_pkg::MAX_STUFFED_PAYLOAD_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [ifbs_pkg::BYTE_W-1:0]   cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [ifbs_pkg::BYTE_W-1:0]   in_data,
	input  wire logic                          in_eom,
	input  wire logic                          q_full,
	output logic                               q_push,
	output ifbs_pkg::job_t                     q_job
);

	logic [ifbs_pkg::BYTE_W-1:0] addr_q;
	logic                        in_frame_q;
	logic                        seq_q;
	logic [ifbs_pkg::BYTE_W-1:0] check_q;
	logic [ifbs_pkg::CNT_W-1:0]  count_q;

	logic                        esc;
	logic [ifbs_pkg::BYTE_W-1:0] code;
	logic [ifbs_pkg::CNT_W-1:0]  base_cnt;
	logic [ifbs_pkg::CNT_W-1:0]  cnt_n;
	logic [ifbs_pkg::BYTE_W-1:0] chk_n;
	logic                        full_frame;
	logic                        close;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	always_comb begin
		esc  = (in_data == ifbs_pkg::FLAG_BYTE) || (in_data == ifbs_pkg::ESC_BYTE);
		code = (in_data == ifbs_pkg::FLAG_BYTE) ? ifbs_pkg::ESC_OF_FLAG : ifbs_pkg::ESC_OF_ESC;
		base_cnt = in_frame_q ? count_q : '0;
		cnt_n    = base_cnt + (esc ? ifbs_pkg::CNT_W'(2) : ifbs_pkg::CNT_W'(1));
		chk_n    = (in_frame_q ? check_q : '0) ^ in_data;
		// next byte may need two line bytes
		full_frame = ({1'b0, cnt_n} + (ifbs_pkg::CNT_W+1)'(2)) >
			(ifbs_pkg::CNT_W+1)'(MAX_STUFFED_PAYLOAD);
		close = in_eom || full_frame;
	end

	always_comb begin
		q_job.hdr   = !in_frame_q;
		q_job.addr  = addr_q;
		q_job.seq   = seq_q;
		q_job.esc   = esc;
		q_job.data  = esc ? code : in_data;
		q_job.close = close;
		q_job.bcc2  = chk_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= ifbs_pkg::ADDR_RESET;
		end else if (cfg_we) begin
			addr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			seq_q      <= 1'b0;
			check_q    <= '0;
			count_q    <= '0;
		end else if (q_push) begin
			if (close) begin
				in_frame_q <= 1'b0;
				seq_q      <= !seq_q;
				check_q    <= '0;
				count_q    <= '0;
			end else begin
				in_frame_q <= 1'b1;
				check_q    <= chk_n;
				count_q    <= cnt_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/ifbs_queue.sv =====
`default_nettype none

module ifbs_queue #(
	parameter int DEPTH = ifbs_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire ifbs_pkg::job_t push_job,
	output logic                full,
	input  wire logic           pop,
	output logic                head_valid,
	output ifbs_pkg::job_t      head_job
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ifbs_pkg::job_t    mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     cnt_q;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/ifbs_back.sv =====
`default_nettype none
`include "info_frame_byte_stuffer_assert.svh"

module ifbs_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         head_valid,
	input  wire ifbs_pkg::job_t               head_job,
	output logic                              pop,
	output logic                              m_valid,
	input  wire logic                         m_ready,
	output logic [ifbs_pkg::BYTE_W-1:0]       m_data,
	output logic                              m_last,
	output logic                              m_closed
);

	ifbs_pkg::phase_t            ph_q;
	ifbs_pkg::phase_t            cur_ph;
	ifbs_pkg::phase_t            nxt_ph;
	logic                        load;
	logic [ifbs_pkg::BYTE_W-1:0] ctrl;
	logic [ifbs_pkg::BYTE_W-1:0] byte_d;
	logic                        closed_d;
	logic                        last_d;

	logic                        valid_q;
	logic [ifbs_pkg::BYTE_W-1:0] data_q;
	logic                        last_q;
	logic                        closed_q;

	assign load = head_valid && (!valid_q || m_ready);
	assign ctrl = head_job.seq ? ifbs_pkg::CTRL_SEQ1 : ifbs_pkg::CTRL_SEQ0;

	always_comb begin
		cur_ph = ph_q;
		if (ph_q == ifbs_pkg::PH_IDLE) begin
			cur_ph = head_job.hdr ? ifbs_pkg::PH_FLAG : ifbs_pkg::PH_DATA0;
		end
	end

	// next state
	always_comb begin
		unique case (cur_ph)
			ifbs_pkg::PH_FLAG:  nxt_ph = ifbs_pkg::PH_ADDR;
			ifbs_pkg::PH_ADDR:  nxt_ph = ifbs_pkg::PH_CTRL;
			ifbs_pkg::PH_CTRL:  nxt_ph = ifbs_pkg::PH_BCC1;
			ifbs_pkg::PH_BCC1:  nxt_ph = ifbs_pkg::PH_DATA0;
			ifbs_pkg::PH_DATA0: begin
				if (head_job.esc) begin
					nxt_ph = ifbs_pkg::PH_DATA1;
				end else begin
					nxt_ph = head_job.close ? ifbs_pkg::PH_BCC2 : ifbs_pkg::PH_IDLE;
				end
			end
			ifbs_pkg::PH_DATA1: nxt_ph = head_job.close ? ifbs_pkg::PH_BCC2 : ifbs_pkg::PH_IDLE;
			ifbs_pkg::PH_BCC2:  nxt_ph = ifbs_pkg::PH_CLOSE;
			default:            nxt_ph = ifbs_pkg::PH_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		closed_d = 1'b0;
		unique case (cur_ph)
			ifbs_pkg::PH_FLAG:  byte_d = ifbs_pkg::FLAG_BYTE;
			ifbs_pkg::PH_ADDR:  byte_d = head_job.addr;
			ifbs_pkg::PH_CTRL:  byte_d = ctrl;
			ifbs_pkg::PH_BCC1:  byte_d = head_job.addr ^ ctrl;
			ifbs_pkg::PH_DATA0: byte_d = head_job.esc ? ifbs_pkg::ESC_BYTE : head_job.data;
			ifbs_pkg::PH_DATA1: byte_d = head_job.data;
			ifbs_pkg::PH_BCC2:  byte_d = head_job.bcc2;
			ifbs_pkg::PH_CLOSE: begin
				byte_d   = ifbs_pkg::FLAG_BYTE;
				closed_d = 1'b1;
			end
			default:            byte_d = ifbs_pkg::FLAG_BYTE;
		endcase
		last_d = (nxt_ph == ifbs_pkg::PH_IDLE);
	end

	assign pop = load && last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= ifbs_pkg::PH_IDLE;
		end else if (load) begin
			ph_q <= nxt_ph;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q   <= byte_d;
			last_q   <= last_d;
			closed_q <= closed_d;
		end
	end

	assign m_valid  = valid_q;
	assign m_data   = data_q;
	assign m_last   = last_q;
	assign m_closed = closed_q;

	`IFBS_ASSERT_IMP(a_close_is_last, clk, arst_n, valid_q && closed_q, last_q)
	`IFBS_ASSERT_IMP(a_close_is_flag, clk, arst_n, valid_q && closed_q, data_q == ifbs_pkg::FLAG_BYTE)
	`IFBS_ASSERT_IMP(a_pop_has_job, clk, arst_n, pop, head_valid)
	`IFBS_ASSERT_NXT(a_pop_rearms, clk, arst_n, pop, ph_q == ifbs_pkg::PH_IDLE)

endmodule

`default_nettype wire

// ===== rtl/core/info_frame_byte_stuffer.sv =====
// Framer with byte stuffing for HDLC-style information frames.
// Slave stream: s_tdata carries one raw payload byte, s_tlast marks the end of message.
// Master stream: m_tdata carries one line byte, m_tlast marks the last line byte
// produced by an input transaction, m_tuser marks the closing flag of a frame.
// cfg_we/cfg_wdata write the address byte (reset 0x03); write only while idle.
// Each input byte yields 1 or 2 data bytes, plus a 4-byte header when it opens a
// frame and BCC2 plus the closing flag when it ends one: 1 to 8 line bytes total.
// The output side emits one line byte per cycle while m_tready does not stall it,
// paced by the byte sequencer in the back end. Classified inputs wait in a small
// queue, so s_tready stays high while the queue has room even as output backs up.
// The first line byte of an input reaches m_tdata through the queue write and
// then the output register.
// When m_tready is low the output register holds, the sequencer stops, and s_tready
// drops once the queue fills. Reset empties the queue, closes any open frame,
// clears the sequence bit and check byte, and restores the address byte.
`default_nettype none

module info_frame_byte_stuffer #(
	parameter int MAX_STUFFED_PAYLOAD = ifbs_pkg::MAX_STUFFED_PAYLOAD_DEF,
	parameter int QUEUE_DEPTH         = ifbs_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [ifbs_pkg::BYTE_W-1:0]  cfg_wdata,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [ifbs_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] data_byte
	input  wire logic                         s_tlast,   // end_of_message
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [ifbs_pkg::BYTE_W-1:0]       m_tdata,   // [7:0] out_byte
	output logic                              m_tlast,   // last_of_run
	output logic                              m_tuser    // [0] frame_closed
);

	logic           q_full;
	logic           q_push;
	logic           q_pop;
	logic           head_valid;
	ifbs_pkg::job_t push_job;
	ifbs_pkg::job_t head_job;

	ifbs_front #(
		.MAX_STUFFED_PAYLOAD(MAX_STUFFED_PAYLOAD)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.in_eom    (s_tlast),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (push_job)
	);

	ifbs_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	ifbs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (q_pop),
		.m_valid    (m_tvalid),
		.m_ready    (m_tready),
		.m_data     (m_tdata),
		.m_last     (m_tlast),
		.m_closed   (m_tuser)
	);

endmodule

`default_nettype wire

// ===== test/tb_info_frame_byte_stuffer.sv =====
module tb_info_frame_byte_stuffer;
	import ifbs_pkg::*;

	localparam int FRAME_LIMIT = MAX_STUFFED_PAYLOAD_DEF;
	localparam int DRAIN_SLACK = 12;

	typedef struct {
		logic [BYTE_W-1:0] octet;
		logic              run_end;
		logic              closing;
	} line_byte_t;

	// predicts the line stream from accepted payload bytes and checks what comes out
	class line_checker;
		logic [BYTE_W-1:0] addr;
		logic              in_frame;
		logic              seq;
		logic [BYTE_W-1:0] bcc2;
		logic [CNT_W-1:0]  stuffed;
		line_byte_t        line_due[$];
		int                mismatches;

		function new();
			addr = ADDR_RESET;
			in_frame = 1'b0;
			seq = 1'b0;
			bcc2 = '0;
			stuffed = '0;
			mismatches = 0;
		endfunction

		function void push(logic [BYTE_W-1:0] b, logic closing);
			line_byte_t e;
			e.octet = b;
			e.run_end = 1'b0;
			e.closing = closing;
			line_due.push_back(e);
		endfunction

		// returns 1 when this byte closes the frame
		function bit note_payload(logic [BYTE_W-1:0] d, logic eom);
			logic [BYTE_W-1:0] ctrl;
			line_byte_t tail;
			bit shut;
			shut = 0;
			if (!in_frame) begin
				ctrl = seq ? CTRL_SEQ1 : CTRL_SEQ0;
				push(FLAG_BYTE, 1'b0);
				push(addr, 1'b0);
				push(ctrl, 1'b0);
				push(addr ^ ctrl, 1'b0);
				in_frame = 1'b1;
				bcc2 = '0;
				stuffed = '0;
			end
			if (d == FLAG_BYTE || d == ESC_BYTE) begin
				push(ESC_BYTE, 1'b0);
				push(d == FLAG_BYTE ? ESC_OF_FLAG : ESC_OF_ESC, 1'b0);
				stuffed = stuffed + 8'd2;
			end else begin
				push(d, 1'b0);
				stuffed = stuffed + 8'd1;
			end
			bcc2 = bcc2 ^ d;
			// close early if the next byte might not fit once stuffed
			if (eom || int'(stuffed) + 2 > FRAME_LIMIT) begin
				push(bcc2, 1'b0);
				push(FLAG_BYTE, 1'b1);
				seq = ~seq;
				in_frame = 1'b0;
				bcc2 = '0;
				stuffed = '0;
				shut = 1;
			end
			tail = line_due.pop_back();
			tail.run_end = 1'b1;
			line_due.push_back(tail);
			return shut;
		endfunction

		function void check_line_byte(logic [BYTE_W-1:0] b, logic last, logic user);
			line_byte_t e;
			if (line_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected line byte %h last %b closed %b", b, last, user);
				return;
			end
			e = line_due.pop_front();
			if (e.octet !== b || e.run_end !== last || e.closing !== user) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: out_byte %h/%h last %b/%b closed %b/%b (exp/got)",
						e.octet, b, e.run_end, last, e.closing, user);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [BYTE_W-1:0] cfg_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [BYTE_W-1:0] s_tdata;
	logic              s_tlast;
	logic              m_tvalid;
	logic              m_tready;
	logic [BYTE_W-1:0] m_tdata;
	logic              m_tlast;
	logic              m_tuser;

	line_checker chk = new();
	bit          hold_req;
	bit          tx_calm;
	bit          frame_shut;

	info_frame_byte_stuffer #(
		.MAX_STUFFED_PAYLOAD(FRAME_LIMIT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			chk.check_line_byte(m_tdata, m_tlast, m_tuser);
	end

	// line side: short random stalls, calm stretches, one long hold-off on request
	initial begin
		int stall_left;
		int cyc;
		bit rx_calm;
		stall_left = 0;
		cyc = 0;
		rx_calm = 0;
		m_tready <= 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc % 64 == 0)
				rx_calm = ($urandom_range(0, 3) == 0);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (hold_req) begin
					hold_req = 0;
					stall_left = 150;
				end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
					stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
						: $urandom_range(1, 3);
				end
			end
		end
	end

	function automatic int send_gap();
		int r;
		if (tx_calm)
			return 0;
		r = $urandom_range(0, 9);
		if (r < 6)
			return 0;
		else if (r < 9)
			return $urandom_range(1, 3);
		else
			return $urandom_range(6, 25);
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] d, input logic eom);
		int gap;
		gap = send_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= BYTE_W'($urandom);
			s_tlast <= 1'($urandom);
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tlast <= eom;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		frame_shut = chk.note_payload(d, eom);
	endtask

	function automatic logic [BYTE_W-1:0] pick_payload(int esc_pct);
		if ($urandom_range(0, 99) < esc_pct)
			return $urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE;
		return BYTE_W'($urandom);
	endfunction

	task automatic send_message(input int len, input int esc_pct);
		tx_calm = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < len; i++)
			send_byte(pick_payload(esc_pct), i == len - 1);
		tx_calm = 0;
	endtask

	// pause the sender until the line side has delivered everything
	task automatic wait_line_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (chk.line_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic write_addr(input logic [BYTE_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		chk.addr = v;
	endtask

	initial begin
		int sent;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		hold_req = 0;
		tx_calm = 0;
		frame_shut = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// one-byte frames at the reset address, both escapes
		send_byte(8'h00, 1'b1);
		send_byte(FLAG_BYTE, 1'b1);
		send_byte(ESC_BYTE, 1'b1);
		send_byte(8'hff, 1'b1);
		// escape codes and near-neighbors inside one frame
		send_byte(FLAG_BYTE, 1'b0);
		send_byte(ESC_BYTE, 1'b0);
		send_byte(ESC_OF_FLAG, 1'b0);
		send_byte(ESC_OF_ESC, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7c, 1'b0);
		send_byte(8'h7f, 1'b1);

		wait_line_idle();
		write_addr(8'hff);
		send_byte(8'h55, 1'b1);
		send_byte(8'haa, 1'b1);

		wait_line_idle();
		write_addr(8'h00);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b1);

		// address equal to the flag goes out unstuffed
		wait_line_idle();
		write_addr(FLAG_BYTE);
		send_byte(ESC_BYTE, 1'b1);

		// new address written with a frame open takes effect at the next header
		send_byte(8'h11, 1'b0);
		wait_line_idle();
		write_addr(8'h40);
		send_byte(8'h22, 1'b1);
		send_byte(8'h33, 1'b1);

		// one long message closed by a full payload, with the line side held off
		wait_line_idle();
		write_addr(BYTE_W'($urandom));
		hold_req = 1;
		frame_shut = 0;
		while (!frame_shut)
			send_byte(pick_payload(75), 1'b0);

		// short messages under a few addresses
		for (int ph = 0; ph < 4; ph++) begin
			wait_line_idle();
			write_addr(ph == 0 ? 8'hff : ph == 1 ? 8'h00 : BYTE_W'($urandom));
			sent = 0;
			while (sent < 16) begin
				int len;
				len = $urandom_range(1, 8);
				send_message(len, 25);
				sent += len;
			end
		end

		wait_line_idle();
		if (chk.mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
